/* design/peer_table_with_aging_assert.svh */
// Assertion macros shared by the peer table design.
`ifndef PEER_TABLE_WITH_AGING_ASSERT_SVH
`define PEER_TABLE_WITH_AGING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pta_pkg.sv */
package pta_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_SWEEP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SWEEP,
        S_DONE
    } state_t;

    typedef struct packed {
        mode_t        mode;
        logic [63:0]  key_word_0;
        logic [63:0]  key_word_1;
        logic [63:0]  key_word_2;
        logic [63:0]  key_word_3;
        logic [31:0]  ipv4_address;
        logic [15:0]  peer_port;
        logic [31:0]  user_id;
        logic [31:0]  now_seconds;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [31:0]      out_ipv4_address;
        logic [15:0]      out_port;
        logic [31:0]      out_user_id;
        logic [31:0]      out_last_seen;
        logic             out_online;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] online_count;
    } rsp_t;

    typedef struct packed {
        logic [63:0] key_0;
        logic [63:0] key_1;
        logic [63:0] key_2;
        logic [63:0] key_3;
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] user;
        logic [31:0] seen;
        logic        online;
    } entry_t;

endpackage

/* design/peer_table_with_aging.sv */
// Peer table with aging: a table of peers keyed by a 256-bit node id.
// Requests arrive on req_valid/req_stall/req_data and each yields exactly one
// response on rsp_valid/rsp_stall/rsp_data; a transfer happens on a rising edge
// with valid high and stall low. The timeout register (timeout_reg, in seconds)
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// no request is in progress, as the block itself does not enforce this. All
// entries live in one single-port-read, single-port-write memory with a
// registered read, and every request walks it one entry a cycle. Add and
// lookup stop at a hit, a sweep walks every entry, and remove then shifts each
// later entry down one place; the response becomes valid as the block returns
// to idle, so the next request can be accepted while the response is held.
// Only one request is in progress at a time; req_stall is high from acceptance
// until the response has been loaded into the output register.
// The output register lets a new request be accepted while the previous
// response is still held under rsp_stall; a finished request waits for it.
// Reset clears the entry and online counts, restores the timeout to 30 and
// empties the output register; the memory contents need no clearing, as no
// entry at or above the entry count is ever read.
module peer_table_with_aging (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  pta_pkg::req_t            req_data,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output pta_pkg::rsp_t            rsp_data,
    input  logic                     cfg_wr_en,
    input  logic [15:0]              cfg_wr_data
);
    import pta_pkg::*;

    `include "peer_table_with_aging_assert.svh"

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] online_reg, online_next;
    logic [15:0]      timeout_reg, timeout_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    rsp_t             res_reg, res_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    entry_t           mem [TABLE_DEPTH];
    entry_t           mem_q;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    logic             hit;
    logic             issue;
    logic [31:0]      age;
    entry_t           new_entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            online_reg    <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            online_reg    <= online_next;
            timeout_reg   <= timeout_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rd_idx_reg <= rd_idx_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    always_comb
    begin
        hit = rd_vld_reg
            && (mem_q.key_0 == req_reg.key_word_0)
            && (mem_q.key_1 == req_reg.key_word_1)
            && (mem_q.key_2 == req_reg.key_word_2)
            && (mem_q.key_3 == req_reg.key_word_3);
        issue = (idx_reg < count_reg);
        age   = req_reg.now_seconds - mem_q.seen;

        new_entry.key_0   = req_reg.key_word_0;
        new_entry.key_1   = req_reg.key_word_1;
        new_entry.key_2   = req_reg.key_word_2;
        new_entry.key_3   = req_reg.key_word_3;
        new_entry.address = req_reg.ipv4_address;
        new_entry.port    = req_reg.peer_port;
        new_entry.user    = req_reg.user_id;
        new_entry.seen    = req_reg.now_seconds;
        new_entry.online  = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        online_next    = online_reg;
        timeout_next   = timeout_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = rd_idx_reg;
        mem_wdata      = mem_q;
        req_stall      = (state_reg != S_IDLE);

        if (cfg_wr_en)
        begin
            timeout_next = cfg_wr_data;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    idx_next = '0;
                    res_next = '0;
                    if (req_data.mode == MODE_SWEEP)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    res_next.found = 1'b1;
                    case (req_reg.mode)
                        MODE_ADD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = rd_idx_reg;
                            mem_wdata = new_entry;
                            if (!mem_q.online)
                            begin
                                online_next = online_reg + CNT_W'(1);
                            end
                            state_next = S_DONE;
                        end
                        MODE_REMOVE:
                        begin
                            if (mem_q.online)
                            begin
                                online_next = online_reg - CNT_W'(1);
                            end
                            idx_next   = {1'b0, rd_idx_reg} + CNT_W'(1);
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            res_next.out_ipv4_address = mem_q.address;
                            res_next.out_port         = mem_q.port;
                            res_next.out_user_id      = mem_q.user;
                            res_next.out_last_seen    = mem_q.seen;
                            res_next.out_online       = mem_q.online;
                            state_next                = S_DONE;
                        end
                    endcase
                end
                else if (issue)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[IDX_W-1:0];
                    idx_next    = idx_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg)
                begin
                    if (req_reg.mode == MODE_ADD)
                    begin
                        if (count_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = count_reg[IDX_W-1:0];
                            mem_wdata   = new_entry;
                            count_next  = count_reg + CNT_W'(1);
                            online_next = online_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res_next.status = STATUS_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg - IDX_W'(1);
                    mem_wdata = mem_q;
                end
                if (issue)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[IDX_W-1:0];
                    idx_next    = idx_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_SWEEP:
            begin
                if (rd_vld_reg && mem_q.online && (age > {16'd0, timeout_reg}))
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = rd_idx_reg;
                    mem_wdata        = mem_q;
                    mem_wdata.online = 1'b0;
                    online_next      = online_reg - CNT_W'(1);
                end
                if (issue)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[IDX_W-1:0];
                    idx_next    = idx_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next              = res_reg;
                    rsp_next.entry_count  = count_reg;
                    rsp_next.online_count = online_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `PTA_ASSERT_NOW(a_online_within_count, 1'b1, online_reg <= count_reg,
        "Online count exceeds entry count")
    `PTA_ASSERT_NOW(a_count_within_depth, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH),
        "Entry count exceeds table depth")
    `PTA_ASSERT_NOW(a_no_write_when_idle, (state_reg == S_IDLE) || (state_reg == S_DONE),
        !mem_we, "Memory written outside a request")
    `PTA_ASSERT_NEXT(a_count_single_step, 1'b1,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1))
        || (count_reg == $past(count_reg) - CNT_W'(1)),
        "Entry count moved by more than one")

endmodule
